FILE: sv/swrms_pkg.sv
// Shared types and constants of the sliding-window RMS meter.
package swrms_pkg;

  // Default sizing of the meter.
  localparam int MAX_WINDOW_DEF   = 4096;
  localparam int MAX_CHANNELS_DEF = 8;

  // Field widths.
  localparam int SAMPLE_BITS = 16;
  localparam int CH_W        = 3;
  localparam int RMS_W       = 15;
  localparam int SQ_W        = 2 * SAMPLE_BITS + 1;
  localparam int MAG_W       = SAMPLE_BITS + 1;
  localparam int WL_W        = 13;
  localparam int CC_W        = 4;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 2;

  localparam logic [RMS_W-1:0] RMS_MAX = {RMS_W{1'b1}};

  // Reset values of the configuration registers.
  localparam logic [WL_W-1:0] WINDOW_RESET  = WL_W'(512);
  localparam logic [CC_W-1:0] CHANNEL_RESET = CC_W'(1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH    = 2'd0,
    REG_CHANNEL_COUNT    = 2'd1,
    REG_COMBINE_CHANNELS = 2'd2,
    REG_COMBINE_OP       = 2'd3
  } cfg_reg_t;

  // Frame merge operations.
  localparam logic MERGE_MAX_OP = 1'b0;
  localparam logic MERGE_SUM_OP = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [CH_W-1:0]               channel;
    logic                          frame_end;
    logic                          cut;
  } in_word_t;

  typedef struct packed {
    logic [RMS_W-1:0] rms;
    logic [CH_W-1:0]  out_channel;
  } out_word_t;

endpackage

FILE: sv/sliding_window_rms_meter_unit.sv
// Top level of the sliding-window RMS meter.
//
//  Port group  Direction  Handshake          Carries
//  in_*        input      in_valid/in_stall  sample, channel, frame_end, cut
//  out_*       output     out_valid/out_stall rms, out_channel
//  cfg_*       input      cfg_we             window_length, channel_count,
//                                            combine_channels, combine_op
//
// One word is worked on at a time, and the input stays stalled from the
// acceptance of a word until the block is back in its idle state. A word
// that gives a result passes through the square, merge, read and update
// states, then the bit-serial divider and square root, and is presented
// from the emit state; a combine-mode word that is not the end of its frame
// goes back to idle from the merge state. The single port of the ring memory
// is read and then written for each ring entry.
// Reset is synchronous and active low. The ring memory is not cleared: each
// channel keeps a high-water count of the entries written since the last
// reset or cut, and an entry at or above it reads as zero.
// A finished result waits in the output register. While that register still
// holds an earlier result that the receiver has not taken, the new result
// waits and the input stays stalled.
module sliding_window_rms_meter_unit #(
  parameter int MAX_WINDOW   = swrms_pkg::MAX_WINDOW_DEF,
  parameter int MAX_CHANNELS = swrms_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  swrms_pkg::in_word_t                  in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output swrms_pkg::out_word_t                 out_data,
  input  logic                                 cfg_we,
  input  logic [swrms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swrms_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CHI_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int DEPTH   = MAX_WINDOW * MAX_CHANNELS;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W   = swrms_pkg::SQ_W + IDX_W;
  localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
  localparam int CNTC_W  = $clog2(MAX_CHANNELS + 1);
  localparam int DEN_W   = $clog2(DEPTH + 1);
  localparam int SQ_W    = swrms_pkg::SQ_W;
  localparam int MAG_W   = swrms_pkg::MAG_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQUARE, ST_MERGE, ST_READ, ST_UPDATE, ST_ROOT, ST_EMIT
  } top_state_t;

  // Configuration registers.
  logic [swrms_pkg::WL_W-1:0] window_length_r;
  logic [swrms_pkg::CC_W-1:0] channel_count_r;
  logic                       combine_channels_r;
  logic                       combine_op_r;

  // Per-channel state and the frame merge.
  logic [SUM_W-1:0]  sum_r [MAX_CHANNELS];
  logic [IDX_W-1:0]  idx_r [MAX_CHANNELS];
  logic [IDX_W:0]    hw_r  [MAX_CHANNELS];
  logic [SQ_W-1:0]   merge_r;

  // Word in flight.
  top_state_t                       state_r;
  logic signed [swrms_pkg::SAMPLE_BITS-1:0] sample_r;
  logic [CHI_W-1:0]                 ch_r;
  logic [swrms_pkg::CH_W-1:0]       out_ch_r;
  logic                             fend_r;
  logic [SQ_W-1:0]                  sq_r;
  logic [SQ_W-1:0]                  value_r;
  logic [AW-1:0]                    addr_r;
  logic                             old_ok_r;
  logic [swrms_pkg::RMS_W-1:0]      rms_r;
  logic                             out_valid_r;
  swrms_pkg::out_word_t             out_data_r;

  // Datapath signals.
  logic [MAG_W-1:0]   mag;
  logic [SQ_W:0]      merge_sum;
  logic [SQ_W-1:0]    merged;
  logic [WIN_W-1:0]   win;
  logic [CNTC_W-1:0]  cnt_ch;
  logic [DEN_W-1:0]   den_r;
  logic [SQ_W-1:0]    ram_rdata;
  logic               ram_we;
  logic [SQ_W-1:0]    old_val;
  logic [SUM_W-1:0]   sum_nxt;
  logic [IDX_W:0]     idx_inc;
  logic               root_start;
  logic               root_done;
  logic [swrms_pkg::RMS_W-1:0] root_rms;
  logic               in_ch_ok;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Window length and channel count clamped to their ranges.
  always_comb begin
    if (window_length_r == '0) begin
      win = WIN_W'(1);
    end else if (32'(window_length_r) > MAX_WINDOW) begin
      win = WIN_W'(MAX_WINDOW);
    end else begin
      win = WIN_W'(window_length_r);
    end
    if (channel_count_r == '0) begin
      cnt_ch = CNTC_W'(1);
    end else if (32'(channel_count_r) > MAX_CHANNELS) begin
      cnt_ch = CNTC_W'(MAX_CHANNELS);
    end else begin
      cnt_ch = CNTC_W'(channel_count_r);
    end
  end

  // Magnitude of the sample; the most negative code gives 2^(bits-1).
  assign mag = sample_r[swrms_pkg::SAMPLE_BITS-1]
             ? MAG_W'(-{sample_r[swrms_pkg::SAMPLE_BITS-1], sample_r})
             : MAG_W'(sample_r);

  // Frame merge, the sum form saturating.
  assign merge_sum = {1'b0, merge_r} + {1'b0, sq_r};
  always_comb begin
    if (combine_op_r == swrms_pkg::MERGE_SUM_OP) begin
      merged = merge_sum[SQ_W] ? {SQ_W{1'b1}} : merge_sum[SQ_W-1:0];
    end else begin
      merged = (sq_r > merge_r) ? sq_r : merge_r;
    end
  end

  assign in_ch_ok = (32'(in_data.channel) < MAX_CHANNELS);

  // Ring entry removal and insertion.
  assign old_val = old_ok_r ? ram_rdata : '0;
  assign sum_nxt = sum_r[ch_r] - SUM_W'(old_val) + SUM_W'(value_r);
  assign idx_inc = {1'b0, idx_r[ch_r]} + (IDX_W+1)'(1);
  assign ram_we  = (state_r == ST_UPDATE);
  assign root_start = (state_r == ST_UPDATE);

  swrms_ram #(
    .WIDTH (SQ_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .addr  (addr_r),
    .wdata (value_r),
    .rdata (ram_rdata)
  );

  swrms_root #(
    .NUM_W (SUM_W),
    .DEN_W (DEN_W)
  ) u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .num   (sum_nxt),
    .den   (den_r),
    .done  (root_done),
    .rms   (root_rms)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r    <= swrms_pkg::WINDOW_RESET;
      channel_count_r    <= swrms_pkg::CHANNEL_RESET;
      combine_channels_r <= 1'b0;
      combine_op_r       <= swrms_pkg::MERGE_MAX_OP;
      state_r            <= ST_IDLE;
      out_valid_r        <= 1'b0;
      merge_r            <= '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        sum_r[c] <= '0;
        idx_r[c] <= '0;
        hw_r[c]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (swrms_pkg::cfg_reg_t'(cfg_index))
          swrms_pkg::REG_WINDOW_LENGTH:
            window_length_r <= cfg_wdata[swrms_pkg::WL_W-1:0];
          swrms_pkg::REG_CHANNEL_COUNT:
            channel_count_r <= cfg_wdata[swrms_pkg::CC_W-1:0];
          swrms_pkg::REG_COMBINE_CHANNELS:
            combine_channels_r <= cfg_wdata[0];
          swrms_pkg::REG_COMBINE_OP:
            combine_op_r <= cfg_wdata[0];
          default: ;
        endcase
      end

      // In the emit state the output register is handled below.
      if (out_valid_r && !out_stall && state_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            // A cut clears every sum, index, fill count and the merge first.
            if (in_data.cut) begin
              merge_r <= '0;
              for (int c = 0; c < MAX_CHANNELS; c++) begin
                sum_r[c] <= '0;
                idx_r[c] <= '0;
                hw_r[c]  <= '0;
              end
            end
            sample_r <= in_data.sample;
            fend_r   <= in_data.frame_end;
            if (combine_channels_r) begin
              ch_r     <= '0;
              out_ch_r <= '0;
              den_r    <= DEN_W'(cnt_ch * win);
              state_r  <= ST_SQUARE;
            end else begin
              ch_r     <= CHI_W'(in_data.channel);
              out_ch_r <= in_data.channel;
              den_r    <= DEN_W'(win);
              // A channel beyond the store gives no result.
              if (in_ch_ok) begin
                state_r <= ST_SQUARE;
              end
            end
          end
        end
        ST_SQUARE: begin
          sq_r    <= SQ_W'(mag * mag);
          state_r <= ST_MERGE;
        end
        ST_MERGE: begin
          if (combine_channels_r) begin
            if (fend_r) begin
              value_r <= merged;
              merge_r <= '0;
              state_r <= ST_READ;
            end else begin
              merge_r <= merged;
              state_r <= ST_IDLE;
            end
          end else begin
            value_r <= sq_r;
            state_r <= ST_READ;
          end
          addr_r   <= AW'(AW'(ch_r) * AW'(MAX_WINDOW)) + AW'(idx_r[ch_r]);
          old_ok_r <= ({1'b0, idx_r[ch_r]} < hw_r[ch_r]);
        end
        ST_READ: begin
          // The ring memory presents the old entry in the next cycle.
          state_r <= ST_UPDATE;
        end
        ST_UPDATE: begin
          sum_r[ch_r] <= sum_nxt;
          if (idx_inc > hw_r[ch_r]) begin
            hw_r[ch_r] <= idx_inc;
          end
          if (32'(idx_inc) >= 32'(win)) begin
            idx_r[ch_r] <= '0;
          end else begin
            idx_r[ch_r] <= IDX_W'(idx_inc);
          end
          state_r <= ST_ROOT;
        end
        ST_ROOT: begin
          if (root_done) begin
            rms_r   <= root_rms;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r            <= 1'b1;
            out_data_r.rms         <= rms_r;
            out_data_r.out_channel <= out_ch_r;
            state_r                <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/swrms_ram.sv
// Generic single-port RAM with a registered read.
module swrms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: sv/swrms_root.sv
// Iterative divide followed by an iterative integer square root, saturated.
module swrms_root #(
  parameter int NUM_W = 45,
  parameter int DEN_W = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [NUM_W-1:0]            num,
  input  logic [DEN_W-1:0]            den,
  output logic                        done,
  output logic [swrms_pkg::RMS_W-1:0] rms
);

  localparam int SQI_W  = NUM_W + (NUM_W % 2);
  localparam int ROOT_W = SQI_W / 2;
  localparam int CNT_W  = $clog2(NUM_W + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SQRT} root_state_t;

  root_state_t        state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [NUM_W-1:0]   q_r;
  logic [DEN_W-1:0]   den_r;
  logic [DEN_W:0]     drem_r;
  logic [SQI_W-1:0]   x_r;
  logic [ROOT_W-1:0]  root_r;
  logic [ROOT_W+1:0]  srem_r;

  logic [DEN_W:0]     dtrial;
  logic               dfit;
  logic [ROOT_W+3:0]  strial_rem;
  logic [ROOT_W+3:0]  strial_sub;
  logic               sfit;

  // One quotient bit per cycle.
  assign dtrial = {drem_r[DEN_W-1:0], q_r[NUM_W-1]};
  assign dfit   = dtrial >= {1'b0, den_r};

  // One root bit per cycle.
  assign strial_rem = {srem_r, x_r[SQI_W-1 -: 2]};
  assign strial_sub = (ROOT_W+4)'({root_r, 2'b01});
  assign sfit       = strial_rem >= strial_sub;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            q_r     <= num;
            den_r   <= den;
            drem_r  <= '0;
            cnt_r   <= CNT_W'(NUM_W);
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          drem_r <= dfit ? (dtrial - {1'b0, den_r}) : dtrial;
          q_r    <= {q_r[NUM_W-2:0], dfit};
          if (cnt_r == CNT_W'(1)) begin
            cnt_r   <= CNT_W'(ROOT_W);
            state_r <= ST_SQRT;
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
          if (cnt_r == CNT_W'(1)) begin
            x_r    <= SQI_W'({q_r[NUM_W-2:0], dfit});
            root_r <= '0;
            srem_r <= '0;
          end
        end
        ST_SQRT: begin
          srem_r <= (ROOT_W+2)'(sfit ? (strial_rem - strial_sub) : strial_rem);
          root_r <= {root_r[ROOT_W-2:0], sfit};
          x_r    <= {x_r[SQI_W-3:0], 2'b00};
          if (cnt_r == CNT_W'(1)) begin
            state_r <= ST_IDLE;
            done    <= 1'b1;
            if ({root_r[ROOT_W-2:0], sfit} > ROOT_W'(swrms_pkg::RMS_MAX)) begin
              rms <= swrms_pkg::RMS_MAX;
            end else begin
              rms <= swrms_pkg::RMS_W'({root_r[ROOT_W-2:0], sfit});
            end
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: dv/tb_sliding_window_rms_meter_unit.sv
// Self-checking testbench of the sliding-window RMS meter.
`timescale 1ns / 100ps

module tb_sliding_window_rms_meter_unit;

  localparam int RING_DEPTH = swrms_pkg::MAX_WINDOW_DEF;
  localparam int NUM_CH     = swrms_pkg::MAX_CHANNELS_DEF;
  // Cycles to let pass after the last result before touching the registers,
  // so that a combine-mode word without a result has also come back to idle.
  localparam int SETTLE     = 120;
  localparam int NUM_PHASES = 12;
  localparam int PHASE_LEN  = 150;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  swrms_pkg::in_word_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  swrms_pkg::out_word_t out_data;
  logic                 cfg_we;
  logic [swrms_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [swrms_pkg::CFG_DATA_W-1:0] cfg_wdata;

  sliding_window_rms_meter_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Shadow of the meter: one ring of squares per channel, the running sum
  // of each ring, the write pointers and the partly merged frame.
  logic [swrms_pkg::SQ_W-1:0] sq_ring [0:NUM_CH*RING_DEPTH-1];
  logic [63:0]                ch_sum  [0:NUM_CH-1];
  logic [11:0]                ch_idx  [0:NUM_CH-1];
  logic [63:0]                merge_acc;
  logic [swrms_pkg::WL_W-1:0] win_len;
  logic [swrms_pkg::CC_W-1:0] chan_cnt;
  logic                       combine_en;
  logic                       merge_op;

  swrms_pkg::out_word_t pending_rms[$];
  int                   errors;
  bit                   quiet;

  // One row of the directed table: either a register write or a word, the
  // latter with a hand-worked result where it is obvious.
  typedef struct {
    bit                   is_cfg;
    swrms_pkg::cfg_reg_t  ridx;
    int                   val;
    swrms_pkg::in_word_t  w;
    bit                   typed;
    swrms_pkg::out_word_t exp;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_meter();
    for (int i = 0; i < NUM_CH*RING_DEPTH; i++) sq_ring[i] = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      ch_sum[c] = '0;
      ch_idx[c] = '0;
    end
    merge_acc = '0;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Overwrites the oldest entry of a channel's ring and returns the level.
  function automatic logic [swrms_pkg::RMS_W-1:0] ring_push(int ch, logic [63:0] value,
                                                            logic [63:0] divisor);
    logic [63:0] wlen;
    logic [63:0] root;
    int          slot;
    int          nidx;
    wlen = win_len;
    if (wlen < 1) wlen = 1;
    if (wlen > RING_DEPTH) wlen = RING_DEPTH;
    slot = ch * RING_DEPTH + ch_idx[ch];
    ch_sum[ch] = ch_sum[ch] - sq_ring[slot] + value;
    sq_ring[slot] = value[swrms_pkg::SQ_W-1:0];
    nidx = ch_idx[ch] + 1;
    if (nidx >= wlen) nidx = 0;
    ch_idx[ch] = 12'(nidx);
    root = int_sqrt(ch_sum[ch] / (divisor * wlen));
    return (root > swrms_pkg::RMS_MAX) ? swrms_pkg::RMS_MAX : root[swrms_pkg::RMS_W-1:0];
  endfunction

  function automatic bit predict_level(swrms_pkg::in_word_t w,
                                       output swrms_pkg::out_word_t r);
    logic [63:0] mag;
    logic [63:0] sq;
    logic [63:0] cnt;
    if (w.cut) clear_meter();
    mag = (w.sample < 0) ? 64'(-int'(w.sample)) : 64'(int'(w.sample));
    sq  = mag * mag;
    r   = '0;
    if (combine_en) begin
      cnt = chan_cnt;
      if (cnt < 1) cnt = 1;
      if (cnt > NUM_CH) cnt = NUM_CH;
      if (merge_op == swrms_pkg::MERGE_SUM_OP) begin
        merge_acc = merge_acc + sq;
        if (merge_acc > {swrms_pkg::SQ_W{1'b1}}) merge_acc = {swrms_pkg::SQ_W{1'b1}};
      end else if (sq > merge_acc) begin
        merge_acc = sq;
      end
      if (!w.frame_end) return 1'b0;
      r.rms = ring_push(0, merge_acc, cnt);
      merge_acc = '0;
      return 1'b1;
    end
    r.rms = ring_push(w.channel, sq, 64'd1);
    r.out_channel = w.channel;
    return 1'b1;
  endfunction

  // Waits until every expected result has come and the block has settled.
  task automatic drain();
    while (pending_rms.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // The write enable drops for a cycle after each write.
  task automatic write_reg(swrms_pkg::cfg_reg_t ridx, int val);
    logic [swrms_pkg::CFG_DATA_W-1:0] d;
    d = swrms_pkg::CFG_DATA_W'(val);
    cfg_we    <= 1'b1;
    cfg_index <= ridx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (ridx)
      swrms_pkg::REG_WINDOW_LENGTH:    win_len    = d[swrms_pkg::WL_W-1:0];
      swrms_pkg::REG_CHANNEL_COUNT:    chan_cnt   = d[swrms_pkg::CC_W-1:0];
      swrms_pkg::REG_COMBINE_CHANNELS: combine_en = d[0];
      swrms_pkg::REG_COMBINE_OP:       merge_op   = d[0];
      default: ;
    endcase
  endtask

  // Sends one word and queues its result. Where the expected value is typed,
  // the shadow still runs so that its state follows the block.
  task automatic send_word(swrms_pkg::in_word_t w, bit typed, swrms_pkg::out_word_t exp);
    swrms_pkg::out_word_t r;
    bit                   has;
    int                   gap;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    has = predict_level(w, r);
    if (has) pending_rms.push_back(typed ? exp : r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [swrms_pkg::SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return ($urandom_range(0, 1) == 1) ? 16'sh0001 : 16'shffff;
      3: return '0;
      default: return swrms_pkg::SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic swrms_pkg::in_word_t rand_word(int ch, bit fend);
    swrms_pkg::in_word_t w;
    w.sample    = pick_sample();
    w.channel   = swrms_pkg::CH_W'(ch);
    w.frame_end = fend;
    w.cut       = ($urandom_range(0, 59) == 0);
    return w;
  endfunction

  function automatic dir_row_t blank_row();
    dir_row_t d;
    d.is_cfg = 1'b0;
    d.ridx   = swrms_pkg::REG_WINDOW_LENGTH;
    d.val    = 0;
    d.w      = '0;
    d.typed  = 1'b0;
    d.exp    = '0;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(swrms_pkg::cfg_reg_t ridx, int val);
    dir_row_t d;
    d = blank_row();
    d.is_cfg = 1'b1;
    d.ridx   = ridx;
    d.val    = val;
    return d;
  endfunction

  function automatic dir_row_t word_row(int s, int ch, bit fend, bit cut, bit typed,
                                        int rms);
    dir_row_t d;
    d = blank_row();
    d.w.sample    = swrms_pkg::SAMPLE_BITS'(s);
    d.w.channel   = swrms_pkg::CH_W'(ch);
    d.w.frame_end = fend;
    d.w.cut       = cut;
    d.typed       = typed;
    d.exp.rms     = swrms_pkg::RMS_W'(rms);
    d.exp.out_channel = typed ? swrms_pkg::CH_W'(ch) : '0;
    return d;
  endfunction

  // With a window of one in per-channel mode the level is simply the
  // magnitude of the sample, saturated for full-scale negative input.
  initial begin
    dir_rows.push_back(cfg_row(swrms_pkg::REG_WINDOW_LENGTH, 1));
    dir_rows.push_back(word_row(0, 0, 0, 0, 1, 0));
    dir_rows.push_back(word_row(32767, 7, 0, 0, 1, 32767));
    dir_rows.push_back(word_row(-32768, 3, 0, 0, 1, 32767));
    dir_rows.push_back(word_row(-1, 1, 0, 0, 1, 1));
    dir_rows.push_back(word_row(1, 5, 1, 0, 1, 1));
    dir_rows.push_back(word_row(-32767, 2, 0, 1, 1, 32767));
    // A window beyond the maximum is clamped; a zero window counts as one.
    dir_rows.push_back(cfg_row(swrms_pkg::REG_WINDOW_LENGTH, 8191));
    dir_rows.push_back(word_row(-32768, 0, 0, 0, 0, 0));
    dir_rows.push_back(word_row(100, 6, 0, 0, 0, 0));
    dir_rows.push_back(cfg_row(swrms_pkg::REG_WINDOW_LENGTH, 0));
    dir_rows.push_back(word_row(-200, 4, 0, 0, 1, 200));
    // Combine mode, maximum merge, channel count clamped down to eight.
    dir_rows.push_back(cfg_row(swrms_pkg::REG_CHANNEL_COUNT, 15));
    dir_rows.push_back(cfg_row(swrms_pkg::REG_COMBINE_CHANNELS, 1));
    dir_rows.push_back(word_row(-32768, 5, 0, 0, 0, 0));
    dir_rows.push_back(word_row(3, 0, 1, 0, 0, 0));
    // Sum merge driven into saturation, channel count of zero read as one.
    dir_rows.push_back(cfg_row(swrms_pkg::REG_COMBINE_OP, 1));
    dir_rows.push_back(cfg_row(swrms_pkg::REG_CHANNEL_COUNT, 0));
    for (int i = 0; i < 8; i++) dir_rows.push_back(word_row(-32768, i, 0, 0, 0, 0));
    dir_rows.push_back(word_row(-32768, 0, 1, 0, 0, 0));
    // A partial frame survives a trip through per-channel mode.
    dir_rows.push_back(word_row(-32768, 0, 0, 0, 0, 0));
    dir_rows.push_back(cfg_row(swrms_pkg::REG_COMBINE_CHANNELS, 0));
    dir_rows.push_back(word_row(5, 2, 0, 0, 0, 0));
    dir_rows.push_back(cfg_row(swrms_pkg::REG_COMBINE_CHANNELS, 1));
    dir_rows.push_back(word_row(0, 4, 1, 0, 0, 0));
  end

  // Random back-pressure on the result side in bursts, off in the quiet phase.
  initial begin
    int hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (quiet) begin
        hold = 0;
        out_stall <= 1'b0;
      end else if (hold > 0) begin
        hold--;
      end else if ($urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Every accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    swrms_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rms.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual rms=%0d ch=%0d",
                 $time, out_data.rms, out_data.out_channel);
        errors++;
      end else begin
        want = pending_rms.pop_front();
        if (out_data.rms !== want.rms) begin
          $display("%0t: rms mismatch, expected %0d, actual %0d",
                   $time, want.rms, out_data.rms);
          errors++;
        end
        if (out_data.out_channel !== want.out_channel) begin
          $display("%0t: channel mismatch, expected %0d, actual %0d",
                   $time, want.out_channel, out_data.out_channel);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int                   wl;
    int                   cc;
    int                   nch;
    int                   flen;
    int                   sent;
    swrms_pkg::out_word_t none;
    none       = '0;
    errors     = 0;
    quiet      = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    win_len    = swrms_pkg::WINDOW_RESET;
    chan_cnt   = swrms_pkg::CHANNEL_RESET;
    combine_en = 1'b0;
    merge_op   = swrms_pkg::MERGE_MAX_OP;
    clear_meter();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: registers are only written once the block is idle.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        in_valid <= 1'b0;
        drain();
        write_reg(dir_rows[i].ridx, dir_rows[i].val);
      end else begin
        send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].exp);
      end
    end

    // Random phases, each with its own setting. Windows are mostly short so
    // that the rings wrap often; the last phase runs without any idling.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      in_valid <= 1'b0;
      drain();
      case ($urandom_range(0, 5))
        0: wl = 4096;
        1: wl = $urandom_range(0, 1) ? 8191 : 0;
        2: wl = $urandom_range(41, 600);
        default: wl = $urandom_range(1, 40);
      endcase
      cc = (ph % 4 == 3) ? (($urandom_range(0, 1)) ? 15 : 0) : $urandom_range(1, 8);
      if (ph == NUM_PHASES - 1) quiet = 1'b1;
      write_reg(swrms_pkg::REG_WINDOW_LENGTH, wl);
      write_reg(swrms_pkg::REG_CHANNEL_COUNT, cc);
      write_reg(swrms_pkg::REG_COMBINE_CHANNELS, ph % 2);
      write_reg(swrms_pkg::REG_COMBINE_OP, (ph / 2) % 2);
      nch = (cc < 1) ? 1 : (cc > NUM_CH) ? NUM_CH : cc;
      sent = 0;
      while (sent < PHASE_LEN) begin
        if (!combine_en) begin
          send_word(rand_word($urandom_range(0, NUM_CH - 1), $urandom_range(0, 1) == 1),
                    1'b0, none);
          sent++;
        end else if ($urandom_range(0, 9) != 0) begin
          // Well-formed frame: channels in order, end mark on the last.
          for (int c = 0; c < nch; c++) begin
            send_word(rand_word(c, c == nch - 1), 1'b0, none);
            sent++;
          end
        end else begin
          // Broken frame: one to ten words, any channels, end mark at random.
          flen = $urandom_range(1, 10);
          for (int c = 0; c < flen; c++) begin
            send_word(rand_word($urandom_range(0, NUM_CH - 1), $urandom_range(0, 3) == 0),
                      1'b0, none);
            sent++;
          end
        end
      end
    end

    in_valid <= 1'b0;
    drain();
    if (errors == 0 && pending_rms.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sliding_window_rms_meter_unit.f
sv/swrms_pkg.sv
sv/swrms_ram.sv
sv/swrms_root.sv
sv/sliding_window_rms_meter_unit.sv
dv/tb_sliding_window_rms_meter_unit.sv
